[rtl/core/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, constants and elaboration helpers of the trial division
// factorizer.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int unsigned FactorWidth   = 32;
    localparam int unsigned PrimeLimitMax = 65536;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } ptd_div_status_t;

    // count primes below limit with a sieve of Eratosthenes
    function automatic int unsigned ptd_prime_count(input int unsigned limit);
        logic [PrimeLimitMax-1:0] marks;
        int unsigned              count;
        int unsigned              j;
        marks = '0;
        count = 0;
        for (int unsigned i = 2; i < limit; i++)
        begin
            if (!marks[i])
            begin
                count++;
                j = i + i;
                while (j < limit)
                begin
                    marks[j] = 1'b1;
                    j        = j + i;
                end
            end
        end
        return count;
    endfunction

endpackage

[rtl/core/ptd_num_if.sv]
// ----------------------------------------------------------------------------
// ptd_num_if
// Valid/ready channel that carries one number to be factored.
// ----------------------------------------------------------------------------
interface ptd_num_if #(
    parameter int unsigned W = 32
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

[rtl/core/ptd_fac_if.sv]
// ----------------------------------------------------------------------------
// ptd_fac_if
// Valid/ready channel that carries one factor result.
// ----------------------------------------------------------------------------
interface ptd_fac_if
    import ptd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FactorWidth-1:0] factor;
    logic                   residual;
    logic                   last;

    modport source (output valid, output factor, output residual, output last, input ready);
    modport sink   (input valid, input factor, input residual, input last, output ready);
endinterface

[rtl/core/ptd_prime_rom.sv]
// ----------------------------------------------------------------------------
// ptd_prime_rom
// Ascending table of all primes below PRIME_LIMIT, built at elaboration
// by a sieve, read synchronously with the data in the cycle after the address.
// ----------------------------------------------------------------------------
module ptd_prime_rom
    import ptd_pkg::*;
#(
    parameter int unsigned PRIME_LIMIT = 4096
) (
    input  logic                                  clk,
    input  logic [((ptd_prime_count(PRIME_LIMIT) > 1) ?
                  $clog2(ptd_prime_count(PRIME_LIMIT)) : 1)-1:0] addr,
    output logic [$clog2(PRIME_LIMIT)-1:0]        data
);

    localparam int unsigned PrimeCount = ptd_prime_count(PRIME_LIMIT);
    localparam int unsigned PrimeW     = $clog2(PRIME_LIMIT);

    typedef logic [PrimeW-1:0] rom_t [PrimeCount];

    function automatic rom_t build_rom();
        rom_t                     tab;
        logic [PrimeLimitMax-1:0] marks;
        int unsigned              count;
        int unsigned              j;
        marks = '0;
        count = 0;
        for (int unsigned k = 0; k < PrimeCount; k++)
        begin
            tab[k] = '0;
        end
        for (int unsigned i = 2; i < PRIME_LIMIT; i++)
        begin
            if (!marks[i])
            begin
                tab[count] = PrimeW'(i);
                count++;
                j = i + i;
                while (j < PRIME_LIMIT)
                begin
                    marks[j] = 1'b1;
                    j        = j + i;
                end
            end
        end
        return tab;
    endfunction

    localparam rom_t RomInit = build_rom();

    always_ff @(posedge clk)
    begin
        data <= RomInit[addr];
    end

endmodule

[rtl/core/ptd_divider.sv]
// ----------------------------------------------------------------------------
// ptd_divider
// Restoring divider, one quotient bit per cycle, that divides the residue
// by a table prime and reports quotient and whether the remainder is zero.
// ----------------------------------------------------------------------------
module ptd_divider
    import ptd_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH  = 32,
    parameter int unsigned DIVISOR_WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUMBER_WIDTH-1:0]  dividend,
    input  logic [DIVISOR_WIDTH-1:0] divisor,
    output logic [NUMBER_WIDTH-1:0]  quotient,
    output ptd_div_status_t          status
);

    localparam int unsigned CntW = $clog2(NUMBER_WIDTH);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic [DIVISOR_WIDTH-1:0] rem_reg, rem_next;
    logic [NUMBER_WIDTH-1:0]  quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_WIDTH:0]   trial;
    logic [DIVISOR_WIDTH:0]   diff;
    logic                     fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(NUMBER_WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            quo_next = {quo_reg[NUMBER_WIDTH-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient        = quo_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

[rtl/core/prime_trial_division_factorizer_top.sv]
// ----------------------------------------------------------------------------
// prime_trial_division_factorizer_top
// Factors one number at a time by trial division over a prime table ROM.
// ----------------------------------------------------------------------------
// One number is taken on in_ch when the block is idle. Every table prime
// below PRIME_LIMIT is tried in ascending order; each prime that divides the
// residue is sent on out_ch once per multiplicity, and a residue above one
// that is left at the end of the table goes out with residual set. Inputs 0
// and 1 give a single result of factor 0. The final result of a number has
// last set, and the next number is taken while that result still waits.
// For each table prime the ROM is read, the prime is loaded as divisor and
// the bit-serial divider runs, one quotient bit per cycle; each factor found
// runs the divider again on the quotient with the same prime. The search
// ends as soon as the residue reaches one, and it waits in the emit state
// while out_ch holds off the previous result.
// ----------------------------------------------------------------------------
module prime_trial_division_factorizer_top
    import ptd_pkg::*;
#(
    parameter int unsigned PRIME_LIMIT  = 4096,
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ptd_num_if.sink   in_ch,
    ptd_fac_if.source out_ch
);

    localparam int unsigned PrimeCount = ptd_prime_count(PRIME_LIMIT);
    localparam int unsigned PrimeW     = $clog2(PRIME_LIMIT);
    localparam int unsigned IdxW       = (PrimeCount > 1) ? $clog2(PrimeCount) : 1;
    localparam int unsigned CntW       = $clog2(PrimeCount + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_LATCH = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [PrimeW-1:0]       p_reg, p_next;
    logic [CntW-1:0]         idx_reg, idx_next;
    logic [FactorWidth-1:0]  pend_factor_reg, pend_factor_next;
    logic                    pend_residual_reg, pend_residual_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FactorWidth-1:0]  out_factor_reg, out_factor_next;
    logic                    out_residual_reg, out_residual_next;
    logic                    out_last_reg, out_last_next;

    logic                    div_start;
    logic [NUMBER_WIDTH-1:0] div_quotient;
    ptd_div_status_t         div_status;
    logic [PrimeW-1:0]       rom_data;

    ptd_prime_rom #(
        .PRIME_LIMIT (PRIME_LIMIT)
    ) u_rom (
        .clk  (clk),
        .addr (idx_reg[IdxW-1:0]),
        .data (rom_data)
    );

    ptd_divider #(
        .NUMBER_WIDTH  (NUMBER_WIDTH),
        .DIVISOR_WIDTH (PrimeW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (p_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.factor   = out_factor_reg;
    assign out_ch.residual = out_residual_reg;
    assign out_ch.last     = out_last_reg;

    always_comb
    begin
        state_next         = state_reg;
        n_next             = n_reg;
        p_next             = p_reg;
        idx_next           = idx_reg;
        pend_factor_next   = pend_factor_reg;
        pend_residual_next = pend_residual_reg;
        pend_last_next     = pend_last_reg;
        out_valid_next     = out_valid_reg;
        out_factor_next    = out_factor_reg;
        out_residual_next  = out_residual_reg;
        out_last_next      = out_last_reg;
        div_start          = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    n_next   = in_ch.number;
                    idx_next = '0;
                    if (in_ch.number <= NUMBER_WIDTH'(1))
                    begin
                        pend_factor_next   = '0;
                        pend_residual_next = 1'b0;
                        pend_last_next     = 1'b1;
                        state_next         = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                p_next     = rom_data;
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (div_status.rem_zero)
                    begin
                        n_next             = div_quotient;
                        pend_factor_next   = FactorWidth'(p_reg);
                        pend_residual_next = 1'b0;
                        pend_last_next     = (div_quotient == NUMBER_WIDTH'(1));
                        state_next         = ST_EMIT;
                    end
                    else if (idx_reg == CntW'(PrimeCount - 1))
                    begin
                        pend_factor_next   = FactorWidth'(n_reg);
                        pend_residual_next = 1'b1;
                        pend_last_next     = 1'b1;
                        state_next         = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CntW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_factor_next   = pend_factor_reg;
                    out_residual_next = pend_residual_reg;
                    out_last_next     = pend_last_reg;
                    state_next        = pend_last_reg ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg             <= n_next;
        p_reg             <= p_next;
        pend_factor_reg   <= pend_factor_next;
        pend_residual_reg <= pend_residual_next;
        pend_last_reg     <= pend_last_next;
        out_factor_reg    <= out_factor_next;
        out_residual_reg  <= out_residual_next;
        out_last_reg      <= out_last_next;
    end

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_trivial_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.number <= NUMBER_WIDTH'(1)))
        |=> ((state_reg == ST_EMIT) && pend_last_reg && (pend_factor_reg == '0)))
        else $error("zero or one input did not queue a single empty result");

    a_residual_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_residual_reg) |-> out_last_reg)
        else $error("residual result not marked as last");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg < CntW'(PrimeCount)))
        else $error("table position ran past the prime table");

endmodule

[tb/tb_prime_trial_division_factorizer_top.sv]
// ----------------------------------------------------------------------------
// tb_prime_trial_division_factorizer_top
// Self-checking bench for the trial division factorizer. Numbers go in on
// the number channel. A local sieve and divide loop predict the factor
// sequence of each accepted number, and each factor transfer is compared
// field by field with the oldest prediction. Both channels idle at random,
// and one phase holds the factor channel off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_prime_trial_division_factorizer_top;
    import ptd_pkg::*;

    localparam int unsigned TableLimit  = 4096;
    localparam int unsigned StallCycles = 4000;
    localparam int unsigned IdleLimit   = 100000;
    localparam int unsigned DrainCycles = 100;
    localparam int unsigned RandomItems = 100;
    localparam int unsigned QuietItems  = 25;

    typedef struct packed {
        logic [FactorWidth-1:0] factor;
        logic                   residual;
        logic                   last;
    } factor_result_t;

    logic clk;
    logic rst_n;

    ptd_num_if #(.W(32)) num_ch ();
    ptd_fac_if           fac_ch ();

    prime_trial_division_factorizer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (num_ch),
        .out_ch (fac_ch)
    );

    int unsigned    table_primes[$];
    factor_result_t pending_factors[$];
    int unsigned    mismatch_count;
    int unsigned    stall_req;
    bit             gaps_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic void build_prime_table();
        bit [TableLimit-1:0] crossed;
        int unsigned         j;
        crossed = '0;
        table_primes.delete();
        for (int unsigned i = 2; i < TableLimit; i++)
        begin
            if (!crossed[i])
            begin
                table_primes.push_back(i);
                for (j = i + i; j < TableLimit; j += i)
                    crossed[j] = 1'b1;
            end
        end
    endfunction

    function automatic void predict_factorization(input logic [31:0] number);
        longint unsigned rest;
        longint unsigned p;
        factor_result_t  found[$];
        factor_result_t  entry;
        int unsigned     idx;
        rest = number;
        if (rest <= 1)
        begin
            entry = '{factor: '0, residual: 1'b0, last: 1'b1};
            pending_factors.push_back(entry);
            return;
        end
        idx = 0;
        while (idx < table_primes.size() && rest > 1)
        begin
            p = table_primes[idx];
            while (rest % p == 0)
            begin
                rest  = rest / p;
                entry = '{factor: p[31:0], residual: 1'b0, last: 1'b0};
                found.push_back(entry);
            end
            idx++;
        end
        if (rest > 1)
        begin
            entry = '{factor: rest[31:0], residual: 1'b1, last: 1'b0};
            found.push_back(entry);
        end
        for (int unsigned k = 0; k < found.size(); k++)
        begin
            entry      = found[k];
            entry.last = (k == found.size() - 1);
            pending_factors.push_back(entry);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_number(input logic [31:0] number);
        while (gaps_on && $urandom_range(99) < 16)
        begin
            num_ch.valid <= 1'b0;
            @(negedge clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.number <= number;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        predict_factorization(number);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_number();
        longint unsigned v;
        longint unsigned p;
        int unsigned     sel;
        bit              full;
        sel = $urandom_range(99);
        if (sel < 30)
            return $urandom();
        if (sel < 65)
        begin
            v    = 1;
            full = 1'b0;
            while (!full)
            begin
                if ($urandom_range(9) < 8)
                    p = table_primes[$urandom_range(15)];
                else
                    p = table_primes[$urandom_range(table_primes.size() - 1)];
                if (v * p > 64'hFFFF_FFFF)
                    full = 1'b1;
                else
                    v = v * p;
            end
            return v[31:0];
        end
        if (sel < 80)
            return $urandom_range(4200);
        p = table_primes[$urandom_range(table_primes.size() - 1)];
        v = p * $urandom_range(32'hFFFF_FFFF / p[31:0], 1);
        return v[31:0];
    endfunction

    task automatic test_zero_and_one();
        send_number(32'd0);
        send_number(32'd1);
    endtask

    task automatic test_field_extremes();
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'hAAAA_AAAA);
        send_number(32'h5555_5555);
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd4294967291);
    endtask

    task automatic test_table_boundary();
        send_number(32'd4093);
        send_number(32'd16752649);
        send_number(32'd4096);
        send_number(32'd4097);
        send_number(32'd4099);
        send_number(32'd3001);
        send_number(32'd9006001);
        send_number(32'd4293001441);
        send_number(32'd3486784401);
        send_number(32'd8186);
    endtask

    task automatic test_random_numbers();
        gaps_on = 1'b0;
        for (int unsigned i = 0; i < RandomItems; i++)
        begin
            if (i == QuietItems)
                gaps_on = 1'b1;
            send_number(pick_number());
        end
    endtask

    task automatic test_output_stall();
        gaps_on = 1'b1;
        stall_req++;
        send_number(32'h8000_0000);
        send_number(32'hC000_0000);
        send_number(32'd2176782336);
        send_number(32'd1);
        send_number(32'h4000_0000);
    endtask

    initial
    begin
        int unsigned hold_left;
        int unsigned stall_seen;
        fac_ch.ready = 1'b0;
        hold_left    = 0;
        stall_seen   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                hold_left  = StallCycles;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                fac_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < 16)
                fac_ch.ready <= 1'b0;
            else
                fac_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        factor_result_t want;
        if (rst_n && fac_ch.valid && fac_ch.ready)
        begin
            if (pending_factors.size() == 0)
                report_mismatch($sformatf("unexpected factor %0d", fac_ch.factor));
            else
            begin
                want = pending_factors.pop_front();
                if (fac_ch.factor !== want.factor)
                    report_mismatch($sformatf("factor %0d, want %0d",
                                              fac_ch.factor, want.factor));
                if (fac_ch.residual !== want.residual)
                    report_mismatch($sformatf("residual %0b, want %0b on factor %0d",
                                              fac_ch.residual, want.residual, want.factor));
                if (fac_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b on factor %0d",
                                              fac_ch.last, want.last, want.factor));
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned idle_cycles;
        if ((num_ch.valid && num_ch.ready) || (fac_ch.valid && fac_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("no transfer for %0d cycles", IdleLimit);
            $display("[prime_trial_division_factorizer_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        stall_req      = 0;
        gaps_on        = 1'b1;
        build_prime_table();
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_and_one();
        test_field_extremes();
        test_table_boundary();
        test_random_numbers();
        test_output_stall();

        num_ch.valid <= 1'b0;
        while (pending_factors.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (pending_factors.size() != 0)
            report_mismatch($sformatf("%0d factors never arrived", pending_factors.size()));

        if (mismatch_count == 0)
            $display("[prime_trial_division_factorizer_top] OK");
        else
            $display("[prime_trial_division_factorizer_top] ERROR");
        $finish;
    end

endmodule

[prime_trial_division_factorizer_top.f]
rtl/core/ptd_pkg.sv
rtl/core/ptd_num_if.sv
rtl/core/ptd_fac_if.sv
rtl/core/ptd_prime_rom.sv
rtl/core/ptd_divider.sv
rtl/core/prime_trial_division_factorizer_top.sv
tb/tb_prime_trial_division_factorizer_top.sv
